/* hw/rtl/tbb_pkg.sv */
// shared types and constants for the foreground bounding box block
// no dependencies
`timescale 1ns / 1ps

package tbb_pkg;

  localparam int MAX_EXTENT = 1024;
  localparam int POS_W      = 10;
  localparam int SIZE_W     = 11;
  localparam int SAMPLE_W   = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // queue between front and back
  localparam int QDEPTH = 2;
  localparam int QAW    = $clog2(QDEPTH);

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_X    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_Y    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_Z    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MARGIN    = 3'd4;

  typedef struct packed {
    logic [SIZE_W-1:0]          size_x;
    logic [SIZE_W-1:0]          size_y;
    logic [SIZE_W-1:0]          size_z;
    logic signed [SAMPLE_W-1:0] threshold;
    logic [SIZE_W-1:0]          margin;
  } tbb_cfg_t;

  // classified voxel
  typedef struct packed {
    logic             hit;
    logic [POS_W-1:0] px;
    logic [POS_W-1:0] py;
    logic [POS_W-1:0] pz;
    logic             last;
  } tbb_item_t;

  typedef struct packed {
    logic [SIZE_W-1:0] from_x;
    logic [SIZE_W-1:0] from_y;
    logic [SIZE_W-1:0] from_z;
    logic [SIZE_W-1:0] to_x;
    logic [SIZE_W-1:0] to_y;
    logic [SIZE_W-1:0] to_z;
    logic              found;
  } tbb_box_t;

endpackage

/* hw/rtl/threshold_bounding_box_3d.sv */
// top level of the foreground bounding box block: config registers and wiring
// depends on tbb_pkg, tbb_front, tbb_queue, tbb_back
`timescale 1ns / 1ps

// usage
// - voxel channel (in_*): one voxel per transaction with sample, present flag,
//   x/y/z position and a last marker closing the volume
// - result channel (out_*): one box per volume, posted for the transaction
//   that carried last; from is inclusive, to exclusive, found tells whether
//   any present voxel reached the threshold
// - config channel (cfg_*): register index and data, always ready; write
//   only while no volume is in flight
// - throughput is one voxel per cycle while the receiver keeps up; the front
//   register loads on the accepting edge, the voxel then passes through the
//   two-entry queue, and the result register loads as the last voxel leaves
//   the queue
// - when the receiver stalls, the box sits in the result register; voxels
//   keep flowing into the accumulator until a further last voxel reaches
//   it, then the queue and front stage fill and in_ready drops
// - reset (rst_n low, synchronous) empties the pipeline, clears the
//   running box and sets sizes to 256, threshold and margin to 0
module threshold_bounding_box_3d import tbb_pkg::*; (
  input  logic                       clk,
  input  logic                       rst_n,
  // voxel channel
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic signed [SAMPLE_W-1:0] in_sample,
  input  logic                       in_present,
  input  logic [POS_W-1:0]           in_pos_x,
  input  logic [POS_W-1:0]           in_pos_y,
  input  logic [POS_W-1:0]           in_pos_z,
  input  logic                       in_last,
  // result channel
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [SIZE_W-1:0]          out_from_x,
  output logic [SIZE_W-1:0]          out_from_y,
  output logic [SIZE_W-1:0]          out_from_z,
  output logic [SIZE_W-1:0]          out_to_x,
  output logic [SIZE_W-1:0]          out_to_y,
  output logic [SIZE_W-1:0]          out_to_z,
  output logic                       out_found,
  // config channel
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [CFG_DATA_W-1:0]      cfg_data
);

  tbb_cfg_t  cfg_r;
  tbb_cfg_t  cfg_nxt;
  logic      cfg_we;

  // front to queue
  logic      fq_valid;
  logic      fq_ready;
  tbb_item_t fq_item;
  // queue to back
  logic      qb_valid;
  logic      qb_ready;
  tbb_item_t qb_item;
  tbb_box_t  box;

  // config registers, writes never stall
  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        REG_SIZE_X:    cfg_nxt.size_x    = cfg_data[SIZE_W-1:0];
        REG_SIZE_Y:    cfg_nxt.size_y    = cfg_data[SIZE_W-1:0];
        REG_SIZE_Z:    cfg_nxt.size_z    = cfg_data[SIZE_W-1:0];
        REG_THRESHOLD: cfg_nxt.threshold = $signed(cfg_data[SAMPLE_W-1:0]);
        REG_MARGIN:    cfg_nxt.margin    = cfg_data[SIZE_W-1:0];
        default:       cfg_nxt           = cfg_r;  // unmapped index, ignored
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.size_x    <= SIZE_W'(256);
      cfg_r.size_y    <= SIZE_W'(256);
      cfg_r.size_z    <= SIZE_W'(256);
      cfg_r.threshold <= '0;
      cfg_r.margin    <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // classify each voxel against the threshold
  tbb_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .sample    (in_sample),
    .present   (in_present),
    .pos_x     (in_pos_x),
    .pos_y     (in_pos_y),
    .pos_z     (in_pos_z),
    .last      (in_last),
    .threshold (cfg_r.threshold),
    .q_valid   (fq_valid),
    .q_ready   (fq_ready),
    .q_item    (fq_item)
  );

  // decouples the front from a back that waits on the receiver
  tbb_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (fq_valid),
    .wr_ready (fq_ready),
    .wr_item  (fq_item),
    .rd_valid (qb_valid),
    .rd_ready (qb_ready),
    .rd_item  (qb_item)
  );

  // running min/max and box on the last voxel
  tbb_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (qb_valid),
    .q_ready   (qb_ready),
    .q_item    (qb_item),
    .cfg       (cfg_r),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .box       (box)
  );

  assign out_from_x = box.from_x;
  assign out_from_y = box.from_y;
  assign out_from_z = box.from_z;
  assign out_to_x   = box.to_x;
  assign out_to_y   = box.to_y;
  assign out_to_z   = box.to_z;
  assign out_found  = box.found;

endmodule

/* hw/rtl/tbb_front.sv */
// front stage: takes voxel transactions and classifies them as foreground
// depends on tbb_pkg
`timescale 1ns / 1ps

module tbb_front import tbb_pkg::*; (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic signed [SAMPLE_W-1:0] sample,
  input  logic                       present,
  input  logic [POS_W-1:0]           pos_x,
  input  logic [POS_W-1:0]           pos_y,
  input  logic [POS_W-1:0]           pos_z,
  input  logic                       last,
  input  logic signed [SAMPLE_W-1:0] threshold,
  output logic                       q_valid,
  input  logic                       q_ready,
  output tbb_item_t                  q_item
);

  logic      valid_r;
  logic      valid_nxt;
  tbb_item_t item_r;
  tbb_item_t item_nxt;
  logic      take;

  assign in_ready = !valid_r || q_ready;
  assign take     = in_valid && in_ready;

  always_comb begin
    item_nxt.hit  = present && (sample >= threshold);
    item_nxt.px   = pos_x;
    item_nxt.py   = pos_y;
    item_nxt.pz   = pos_z;
    item_nxt.last = last;
    valid_nxt     = take || (valid_r && !q_ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      item_r <= item_nxt;
    end
  end

  assign q_valid = valid_r;
  assign q_item  = item_r;

`ifndef NO_ASSERTIONS
  // a classified voxel held for the queue keeps its content
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r && !q_ready |=> valid_r && $stable(item_r))
    else $error("front stage lost or changed a held voxel");
`endif

endmodule

/* hw/rtl/tbb_queue.sv */
// short queue of classified voxels between front and back
// depends on tbb_pkg
`timescale 1ns / 1ps

module tbb_queue import tbb_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      wr_valid,
  output logic      wr_ready,
  input  tbb_item_t wr_item,
  output logic      rd_valid,
  input  logic      rd_ready,
  output tbb_item_t rd_item
);

  tbb_item_t          mem [QDEPTH];
  logic [QAW-1:0]     wr_ptr_r;
  logic [QAW-1:0]     wr_ptr_nxt;
  logic [QAW-1:0]     rd_ptr_r;
  logic [QAW-1:0]     rd_ptr_nxt;
  logic [QAW:0]       count_r;
  logic [QAW:0]       count_nxt;
  logic               push;
  logic               pop;

  assign wr_ready = (count_r != (QAW+1)'(QDEPTH));
  assign rd_valid = (count_r != '0);
  assign rd_item  = mem[rd_ptr_r];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QAW'(QDEPTH-1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QAW'(QDEPTH-1)) ? '0 : rd_ptr_r + 1'b1;
    end
    count_nxt = count_r + (QAW+1)'(push) - (QAW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= wr_item;
    end
  end

`ifndef NO_ASSERTIONS
  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= (QAW+1)'(QDEPTH))
    else $error("queue count beyond depth");
  a_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0) |-> (wr_ptr_r == rd_ptr_r))
    else $error("empty queue with unequal pointers");
`endif

endmodule

/* hw/rtl/tbb_back.sv */
// back stage: running min/max per axis, box math and result register
// depends on tbb_pkg
`timescale 1ns / 1ps

module tbb_back import tbb_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      q_valid,
  output logic      q_ready,
  input  tbb_item_t q_item,
  input  tbb_cfg_t  cfg,
  output logic      out_valid,
  input  logic      out_ready,
  output tbb_box_t  box
);

  logic [POS_W-1:0] lo_x_r, lo_y_r, lo_z_r;
  logic [POS_W-1:0] hi_x_r, hi_y_r, hi_z_r;
  logic             any_r;
  logic [POS_W-1:0] lo_x_nxt, lo_y_nxt, lo_z_nxt;
  logic [POS_W-1:0] hi_x_nxt, hi_y_nxt, hi_z_nxt;
  logic             any_nxt;
  logic             out_valid_r;
  logic             out_valid_nxt;
  tbb_box_t         box_r;
  tbb_box_t         box_nxt;
  logic             pop;
  logic             emit;

  // from and to of one axis, packed as {from, to}
  function automatic logic [2*SIZE_W-1:0] axis_box(
    input logic [POS_W-1:0]  lo,
    input logic [POS_W-1:0]  hi,
    input logic              any,
    input logic [SIZE_W-1:0] sz_reg,
    input logic [SIZE_W-1:0] mrg
  );
    logic [SIZE_W-1:0]        sz;
    logic signed [SIZE_W+1:0] f;
    logic [SIZE_W+1:0]        t;
    logic [SIZE_W-1:0]        from_v;
    logic [SIZE_W-1:0]        to_v;
    if (sz_reg == '0) begin
      sz = SIZE_W'(1);
    end else if (sz_reg > SIZE_W'(MAX_EXTENT)) begin
      sz = SIZE_W'(MAX_EXTENT);
    end else begin
      sz = sz_reg;
    end
    f = any ? $signed({3'b000, lo}) : $signed({2'b00, sz});
    f = f - $signed({2'b00, mrg});
    t = any ? ({3'b000, hi} + (SIZE_W+2)'(1)) : (SIZE_W+2)'(1);
    t = t + {2'b00, mrg};
    if (f < 0) begin
      from_v = '0;
    end else if (f > $signed({2'b00, sz})) begin
      from_v = sz;
    end else begin
      from_v = f[SIZE_W-1:0];
    end
    to_v = (t > {2'b00, sz}) ? sz : t[SIZE_W-1:0];
    return {from_v, to_v};
  endfunction

  // a last voxel waits until the result register is free
  assign q_ready = !q_item.last || !out_valid_r || out_ready;
  assign pop     = q_valid && q_ready;
  assign emit    = pop && q_item.last;

  always_comb begin
    lo_x_nxt = lo_x_r;
    lo_y_nxt = lo_y_r;
    lo_z_nxt = lo_z_r;
    hi_x_nxt = hi_x_r;
    hi_y_nxt = hi_y_r;
    hi_z_nxt = hi_z_r;
    any_nxt  = any_r;
    if (pop && q_item.hit) begin
      if (!any_r) begin
        lo_x_nxt = q_item.px;
        lo_y_nxt = q_item.py;
        lo_z_nxt = q_item.pz;
        hi_x_nxt = q_item.px;
        hi_y_nxt = q_item.py;
        hi_z_nxt = q_item.pz;
      end else begin
        if (q_item.px < lo_x_r) lo_x_nxt = q_item.px;
        if (q_item.py < lo_y_r) lo_y_nxt = q_item.py;
        if (q_item.pz < lo_z_r) lo_z_nxt = q_item.pz;
        if (q_item.px > hi_x_r) hi_x_nxt = q_item.px;
        if (q_item.py > hi_y_r) hi_y_nxt = q_item.py;
        if (q_item.pz > hi_z_r) hi_z_nxt = q_item.pz;
      end
      any_nxt = 1'b1;
    end
    {box_nxt.from_x, box_nxt.to_x} = axis_box(lo_x_nxt, hi_x_nxt, any_nxt, cfg.size_x,
                                              cfg.margin);
    {box_nxt.from_y, box_nxt.to_y} = axis_box(lo_y_nxt, hi_y_nxt, any_nxt, cfg.size_y,
                                              cfg.margin);
    {box_nxt.from_z, box_nxt.to_z} = axis_box(lo_z_nxt, hi_z_nxt, any_nxt, cfg.size_z,
                                              cfg.margin);
    box_nxt.found = any_nxt;
    out_valid_nxt = emit || (out_valid_r && !out_ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lo_x_r      <= '0;
      lo_y_r      <= '0;
      lo_z_r      <= '0;
      hi_x_r      <= '0;
      hi_y_r      <= '0;
      hi_z_r      <= '0;
      any_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (emit) begin
        // volume done, start over
        lo_x_r <= '0;
        lo_y_r <= '0;
        lo_z_r <= '0;
        hi_x_r <= '0;
        hi_y_r <= '0;
        hi_z_r <= '0;
        any_r  <= 1'b0;
      end else begin
        lo_x_r <= lo_x_nxt;
        lo_y_r <= lo_y_nxt;
        lo_z_r <= lo_z_nxt;
        hi_x_r <= hi_x_nxt;
        hi_y_r <= hi_y_nxt;
        hi_z_r <= hi_z_nxt;
        any_r  <= any_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      box_r <= box_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign box       = box_r;

`ifndef NO_ASSERTIONS
  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    emit |=> !any_r && out_valid_r)
    else $error("state not cleared or result not posted after last voxel");
  a_order: assert property (@(posedge clk) disable iff (!rst_n)
    any_r |-> (lo_x_r <= hi_x_r) && (lo_y_r <= hi_y_r) && (lo_z_r <= hi_z_r))
    else $error("running minimum above running maximum");
`endif

endmodule
